[hdl/assert_macros.svh]
// Assertion macros shared by the mapper RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tfam_pkg.sv]
// Package for the time-slot flash address mapper: field widths, codes,
// register reset values and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package tfam_pkg;

   localparam int DEFAULT_ADDRESS_BITS = 32;

   localparam int MODE_W       = 2;
   localparam int TIME_W       = 32;
   localparam int FLASH_ADDR_W = 32;
   localparam int BASE_W       = 32;
   localparam int SECTOR_W     = 25;
   localparam int RECORD_W     = 17;
   localparam int PERIOD_W     = 32;
   localparam int INTERVAL_W   = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [MODE_W-1:0] MODE_WRITE        = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ         = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOCK_CHANGE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_SIZE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_SIZE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_PERIOD    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_INTERVAL = 3'd4;

   localparam logic [BASE_W-1:0]     RESET_BASE_ADDRESS  = 32'd0;
   localparam logic [SECTOR_W-1:0]   RESET_SECTOR_SIZE   = 25'd4096;
   localparam logic [RECORD_W-1:0]   RESET_RECORD_SIZE   = 17'd16;
   localparam logic [PERIOD_W-1:0]   RESET_LOG_PERIOD    = 32'd86400;
   localparam logic [INTERVAL_W-1:0] RESET_SLOT_INTERVAL = 32'd60;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_GOT_RPS,
      ST_GOT_Q,
      ST_GOT_UC,
      ST_GOT_MOD,
      ST_GOT_SLOT,
      ST_GOT_UNIT,
      ST_MUL_UNIT,
      ST_ADD_UNIT,
      ST_ADD_OFF,
      ST_GOT_SECT,
      ST_FINISH
   } tfam_state_type;

endpackage

[hdl/tfam_req_if.sv]
// Request channel: access mode and time stamps.
// Depends on tfam_pkg.
`timescale 1ns / 1ps

interface tfam_req_if import tfam_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [TIME_W-1:0]   time_now;
   logic [TIME_W-1:0]   time_new;

   modport source (output valid, mode, time_now, time_new, input ready);
   modport sink   (input valid, mode, time_now, time_new, output ready);
endinterface

[hdl/tfam_rsp_if.sv]
// Response channel: flash address, erase flag and status.
// Depends on tfam_pkg.
`timescale 1ns / 1ps

interface tfam_rsp_if import tfam_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FLASH_ADDR_W-1:0] flash_address;
   logic                    erase_before_write;
   logic                    status;

   modport source (output valid, flash_address, erase_before_write, status, input ready);
   modport sink   (input valid, flash_address, erase_before_write, status, output ready);
endinterface

[hdl/tfam_csr_if.sv]
// Configuration write channel: register index and write data.
// Depends on tfam_pkg.
`timescale 1ns / 1ps

interface tfam_csr_if import tfam_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/timeslot_flash_address_mapper_core.sv]
// Time-slot flash address mapper: one shared restoring divider and one
// shared 32x25 multiplier under a sequencer. Depends on tfam_pkg, the three
// channel interfaces and assert_macros.svh.
//
//   channel | dir | transaction payload
//   req_ch  | in  | mode, time_now, time_new
//   rsp_ch  | out | flash_address, erase_before_write, status
//   csr_ch  | in  | index, data (register write, always ready)
//
// Divisions are DIV_W bits wide, DIV_W = max(ADDRESS_BITS, 33); the divider sets the rate.
// Read: 5 or 6 divisions; write adds one division; clock change takes 9 to 11
// divisions.
// req_ch is ready only while the sequencer is idle; a finished transaction waits in the
// response register, and the next request is taken meanwhile. FINISH holds while the
// response register is full and rsp_ch is not ready. Reset is synchronous.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timeslot_flash_address_mapper_core import tfam_pkg::*; #(
   parameter int ADDRESS_BITS = DEFAULT_ADDRESS_BITS
) (
   input  logic     clock,
   input  logic     reset,
   tfam_req_if.sink   req_ch,
   tfam_rsp_if.source rsp_ch,
   tfam_csr_if.sink   csr_ch
);

   localparam int DIV_W = (ADDRESS_BITS > 33) ? ADDRESS_BITS : 33;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int MUL_W = 32 + SECTOR_W;

   tfam_state_type state_ff, state_in, ret_ff, ret_in;

   logic [BASE_W-1:0]       base_ff, base_in;
   logic [SECTOR_W-1:0]     sector_ff, sector_in;
   logic [RECORD_W-1:0]     record_ff, record_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic [INTERVAL_W-1:0]   interval_ff, interval_in;
   logic                    pending_ff, pending_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [TIME_W-1:0]       tnow_ff, tnow_in;
   logic [TIME_W-1:0]       tnew_ff, tnew_in;
   logic                    pass_ff, pass_in;
   logic [SECTOR_W-1:0]     rps_ff, rps_in;
   logic [31:0]             uc_ff, uc_in;
   logic [31:0]             unit_ff, unit_in;
   logic [SECTOR_W-1:0]     off_ff, off_in;
   logic [MUL_W-1:0]        prod_ff, prod_in;
   logic [ADDRESS_BITS-1:0] acc_ff, acc_in;
   logic [FLASH_ADDR_W-1:0] addr_ff, addr_in;
   logic [DIV_W-1:0]        sect_ff, sect_in;
   logic                    res_erase_ff, res_erase_in;
   logic                    res_status_ff, res_status_in;
   logic [DIV_W-1:0]        dvd_ff, dvd_in;
   logic [32:0]             rem_ff, rem_in;
   logic [31:0]             dvs_ff, dvs_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FLASH_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic                    rsp_erase_ff, rsp_erase_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic                    req_take, csr_take, rsp_load, cfg_bad;
   logic [32:0]             rem_shift, rem_diff, uc_dividend;
   logic                    div_take;
   logic [31:0]             mul_a;
   logic [SECTOR_W-1:0]     mul_b;
   logic [ADDRESS_BITS-1:0] acc_sum;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign csr_take      = csr_ch.valid;
   assign rsp_load      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.flash_address      = rsp_addr_ff;
   assign rsp_ch.erase_before_write = rsp_erase_ff;
   assign rsp_ch.status             = rsp_status_ff;

   assign cfg_bad = (record_ff == '0) || (SECTOR_W'(record_ff) > sector_ff) ||
                    (period_ff == '0) || (interval_ff == '0);

   assign rem_shift   = {rem_ff[31:0], dvd_ff[DIV_W-1]};
   assign div_take    = rem_shift >= {1'b0, dvs_ff};
   assign rem_diff    = rem_shift - {1'b0, dvs_ff};
   assign uc_dividend = {1'b0, dvd_ff[31:0]} + 33'(rps_ff) - 33'd1;
   assign acc_sum     = acc_ff + ADDRESS_BITS'(prod_ff);

   always_comb begin
      if (state_ff == ST_MUL_UNIT) begin
         mul_a = unit_ff;
         mul_b = sector_ff;
      end else begin
         mul_a = 32'(off_ff);
         mul_b = SECTOR_W'(record_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = cfg_bad ? ST_FINISH : ST_DIV;
               ret_in   = ST_GOT_RPS;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) state_in = ret_ff;
         end
         ST_GOT_RPS: begin
            state_in = ST_DIV;
            ret_in   = ST_GOT_Q;
         end
         ST_GOT_Q: begin
            state_in = ST_DIV;
            ret_in   = ST_GOT_UC;
         end
         ST_GOT_UC: begin
            state_in = (dvd_ff == '0) ? ST_FINISH : ST_DIV;
            ret_in   = ST_GOT_MOD;
         end
         ST_GOT_MOD: begin
            state_in = ST_DIV;
            ret_in   = ST_GOT_SLOT;
         end
         ST_GOT_SLOT: begin
            state_in = (dvd_ff == '0) ? ST_MUL_UNIT : ST_DIV;
            ret_in   = ST_GOT_UNIT;
         end
         ST_GOT_UNIT: state_in = ST_MUL_UNIT;
         ST_MUL_UNIT: state_in = ST_ADD_UNIT;
         ST_ADD_UNIT: state_in = ST_ADD_OFF;
         ST_ADD_OFF: begin
            if (pass_ff || (mode_ff inside {MODE_WRITE, MODE_CLOCK_CHANGE})) begin
               state_in = ST_DIV;
               ret_in   = ST_GOT_SECT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_GOT_SECT: begin
            if (!pass_ff && (mode_ff == MODE_CLOCK_CHANGE)) begin
               state_in = ST_DIV;
               ret_in   = ST_GOT_MOD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      base_in       = base_ff;
      sector_in     = sector_ff;
      record_in     = record_ff;
      period_in     = period_ff;
      interval_in   = interval_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mode_in       = mode_ff;
      tnow_in       = tnow_ff;
      tnew_in       = tnew_ff;
      pass_in       = pass_ff;
      rps_in        = rps_ff;
      uc_in         = uc_ff;
      unit_in       = unit_ff;
      off_in        = off_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      addr_in       = addr_ff;
      sect_in       = sect_ff;
      res_erase_in  = res_erase_ff;
      res_status_in = res_status_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_erase_in  = rsp_erase_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mode_in       = req_ch.mode;
               tnow_in       = req_ch.time_now;
               tnew_in       = req_ch.time_new;
               pass_in       = 1'b0;
               res_status_in = cfg_bad;
               res_erase_in  = 1'b0;
               addr_in       = '0;
               dvd_in        = DIV_W'(sector_ff);
               dvs_in        = 32'(record_ff);
               rem_in        = '0;
               cnt_in        = CNT_W'(DIV_W - 1);
            end
         end
         ST_DIV: begin
            dvd_in = {dvd_ff[DIV_W-2:0], div_take};
            rem_in = div_take ? rem_diff : rem_shift;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         ST_GOT_RPS: begin
            rps_in = dvd_ff[SECTOR_W-1:0];
            dvd_in = DIV_W'(period_ff);
            dvs_in = interval_ff;
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W - 1);
         end
         ST_GOT_Q: begin
            dvd_in = DIV_W'(uc_dividend);
            dvs_in = 32'(rps_ff);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W - 1);
         end
         ST_GOT_UC: begin
            uc_in         = dvd_ff[31:0];
            res_status_in = (dvd_ff == '0);
            dvd_in        = DIV_W'(tnow_ff);
            dvs_in        = period_ff;
            rem_in        = '0;
            cnt_in        = CNT_W'(DIV_W - 1);
         end
         ST_GOT_MOD: begin
            dvd_in = DIV_W'(rem_ff[31:0]);
            dvs_in = interval_ff;
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W - 1);
         end
         ST_GOT_SLOT: begin
            if (dvd_ff == '0) begin
               unit_in = uc_ff - 32'd1;
               off_in  = rps_ff - SECTOR_W'(1);
            end else begin
               dvd_in = DIV_W'(dvd_ff[31:0] - 32'd1);
               dvs_in = 32'(rps_ff);
               rem_in = '0;
               cnt_in = CNT_W'(DIV_W - 1);
            end
         end
         ST_GOT_UNIT: begin
            unit_in = dvd_ff[31:0];
            off_in  = rem_ff[SECTOR_W-1:0];
         end
         ST_MUL_UNIT: begin
            prod_in = mul_a * mul_b;
            acc_in  = ADDRESS_BITS'(base_ff);
         end
         ST_ADD_UNIT: begin
            acc_in  = acc_sum;
            prod_in = mul_a * mul_b;
         end
         ST_ADD_OFF: begin
            acc_in = acc_sum;
            if (!pass_ff) addr_in = FLASH_ADDR_W'(acc_sum);
            dvd_in = DIV_W'(acc_sum);
            dvs_in = 32'(sector_ff);
            rem_in = '0;
            cnt_in = CNT_W'(DIV_W - 1);
         end
         ST_GOT_SECT: begin
            if (pass_ff) begin
               if (dvd_ff != sect_ff) pending_in = 1'b1;
            end else if (mode_ff == MODE_WRITE) begin
               res_erase_in = (rem_ff == '0) || pending_ff;
               pending_in   = 1'b0;
            end else if (mode_ff == MODE_CLOCK_CHANGE) begin
               sect_in = dvd_ff;
               pass_in = 1'b1;
               dvd_in  = DIV_W'(tnew_ff);
               dvs_in  = period_ff;
               rem_in  = '0;
               cnt_in  = CNT_W'(DIV_W - 1);
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_status_ff ? '0 : addr_ff;
               rsp_erase_in  = res_status_ff ? 1'b0 : res_erase_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: ;
      endcase

      if (csr_take) begin
         case (csr_ch.index)
            CSR_BASE_ADDRESS: begin
               base_in    = csr_ch.data[BASE_W-1:0];
               pending_in = 1'b1;
            end
            CSR_SECTOR_SIZE: begin
               sector_in  = csr_ch.data[SECTOR_W-1:0];
               pending_in = 1'b1;
            end
            CSR_RECORD_SIZE: begin
               record_in  = csr_ch.data[RECORD_W-1:0];
               pending_in = 1'b1;
            end
            CSR_LOG_PERIOD: begin
               period_in  = csr_ch.data[PERIOD_W-1:0];
               pending_in = 1'b1;
            end
            CSR_SLOT_INTERVAL: begin
               interval_in = csr_ch.data[INTERVAL_W-1:0];
               pending_in  = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         base_ff      <= RESET_BASE_ADDRESS;
         sector_ff    <= RESET_SECTOR_SIZE;
         record_ff    <= RESET_RECORD_SIZE;
         period_ff    <= RESET_LOG_PERIOD;
         interval_ff  <= RESET_SLOT_INTERVAL;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         base_ff      <= base_in;
         sector_ff    <= sector_in;
         record_ff    <= record_in;
         period_ff    <= period_in;
         interval_ff  <= interval_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      tnow_ff       <= tnow_in;
      tnew_ff       <= tnew_in;
      pass_ff       <= pass_in;
      rps_ff        <= rps_in;
      uc_ff         <= uc_in;
      unit_ff       <= unit_in;
      off_ff        <= off_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      addr_ff       <= addr_in;
      sect_ff       <= sect_in;
      res_erase_ff  <= res_erase_in;
      res_status_ff <= res_status_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_erase_ff  <= rsp_erase_in;
      rsp_status_ff <= rsp_status_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, !req_ch.ready,
      "sequencer idle after accept")
   `ASSERT_IMPLY(a_error_clears_fields, clock, reset, rsp_valid_ff && rsp_status_ff,
      (rsp_addr_ff == '0) && !rsp_erase_ff, "error response carries data")
   `ASSERT_NEXT(a_csr_rearms_erase, clock, reset,
      csr_take && (csr_ch.index <= CSR_SLOT_INTERVAL), pending_ff,
      "register write did not arm erase")

endmodule

[tb/tb_top.sv]
// Self-checking bench for timeslot_flash_address_mapper_core: directed and random
// access transactions under many register layouts, checked against an in-bench mapper.
// Depends on tfam_pkg, the tfam_req_if, tfam_rsp_if and tfam_csr_if interfaces and the core.
`timescale 1ns / 1ps

module tb_top;
   import tfam_pkg::*;

   localparam int unsigned RUN_LIMIT    = 4_000_000;
   localparam int unsigned DRAIN_SETTLE = 4;
   localparam int unsigned END_SETTLE   = 500;
   localparam int unsigned RANDOM_ITEMS = 600;
   localparam logic [63:0] ADDR_MASK    = (DEFAULT_ADDRESS_BITS >= 64) ? '1 :
                                          ((64'd1 << DEFAULT_ADDRESS_BITS) - 64'd1);

   localparam logic [MODE_W-1:0]      MODE_UNUSED    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI  = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TIME_W-1:0] time_now;
      logic [TIME_W-1:0] time_new;
   } access_type;

   typedef struct packed {
      logic [FLASH_ADDR_W-1:0] flash_address;
      logic                    erase_before_write;
      logic                    status;
   } mapping_type;

   typedef enum logic [1:0] {CMD_ACCESS, CMD_CSR, CMD_DRAIN, CMD_PACE} command_kind_type;

   typedef struct {
      command_kind_type       kind;
      access_type             acc;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      bit                     flag;
   } command_type;

   logic clock;
   logic reset;

   tfam_req_if req_ch ();
   tfam_rsp_if rsp_ch ();
   tfam_csr_if csr_ch ();

   timeslot_flash_address_mapper_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   command_type pending[$];
   mapping_type expected_mappings[$];
   bit          idle_off;
   int unsigned gap_left;
   int unsigned settle_left;
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned access_count;
   int unsigned csr_count;
   int unsigned layout_count;
   int unsigned erase_count;
   int unsigned invalid_count;
   int unsigned clock_change_count;

   // mapper state mirrored by the bench
   logic [BASE_W-1:0]     cfg_base;
   logic [SECTOR_W-1:0]   cfg_sector;
   logic [RECORD_W-1:0]   cfg_record;
   logic [PERIOD_W-1:0]   cfg_period;
   logic [INTERVAL_W-1:0] cfg_interval;
   logic [63:0]           recs_per_sector;
   logic [63:0]           unit_total;
   logic                  erase_pending;

   // layout as planned by the stimulus, used only to aim time stamps
   logic [31:0] p_period;
   logic [31:0] p_interval;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == RUN_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", RUN_LIMIT,
               expected_mappings.size());
      $display("tb_top failed");
      $finish;
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t ns: %s mismatch: got 0x%08h, expected 0x%08h", $time, what, got, want);
   endtask

   function automatic void derive_layout();
      bit bad;
      bad = (cfg_record == 0) || (cfg_record > cfg_sector) || (cfg_period == 0) ||
            (cfg_interval == 0);
      if (bad) begin
         recs_per_sector = 0;
         unit_total      = 0;
      end else begin
         recs_per_sector = cfg_sector / cfg_record;
         unit_total      = (cfg_period / cfg_interval + recs_per_sector - 1) / recs_per_sector;
      end
   endfunction

   function automatic void restore_defaults();
      cfg_base     = RESET_BASE_ADDRESS;
      cfg_sector   = RESET_SECTOR_SIZE;
      cfg_record   = RESET_RECORD_SIZE;
      cfg_period   = RESET_LOG_PERIOD;
      cfg_interval = RESET_SLOT_INTERVAL;
      derive_layout();
      erase_pending = 1'b1;
   endfunction

   function automatic void write_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BASE_ADDRESS:  cfg_base     = value[BASE_W-1:0];
         CSR_SECTOR_SIZE:   cfg_sector   = value[SECTOR_W-1:0];
         CSR_RECORD_SIZE:   cfg_record   = value[RECORD_W-1:0];
         CSR_LOG_PERIOD:    cfg_period   = value[PERIOD_W-1:0];
         CSR_SLOT_INTERVAL: cfg_interval = value[INTERVAL_W-1:0];
         default: return;
      endcase
      derive_layout();
      erase_pending = 1'b1;
   endfunction

   function automatic logic [63:0] slot_address(logic [TIME_W-1:0] stamp);
      logic [63:0] slot;
      logic [63:0] unit;
      logic [63:0] offset;
      slot = (stamp % cfg_period) / cfg_interval;
      if (slot == 0) begin
         unit   = unit_total - 1;
         offset = recs_per_sector - 1;
      end else begin
         slot   = slot - 1;
         unit   = slot / recs_per_sector;
         offset = slot % recs_per_sector;
      end
      return (cfg_base + unit * cfg_sector + offset * cfg_record) & ADDR_MASK;
   endfunction

   function automatic mapping_type map_access(access_type a);
      mapping_type r;
      logic [63:0] addr;
      r = '0;
      if (unit_total == 0) begin
         r.status = 1'b1;
         return r;
      end
      addr = slot_address(a.time_now);
      if (a.mode == MODE_WRITE) begin
         r.erase_before_write = (addr % cfg_sector == 0) || erase_pending;
         erase_pending = 1'b0;
      end else if (a.mode == MODE_CLOCK_CHANGE) begin
         if (addr / cfg_sector != slot_address(a.time_new) / cfg_sector) erase_pending = 1'b1;
      end
      r.flash_address = addr[FLASH_ADDR_W-1:0];
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (idle_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 30);
      return $urandom_range(50, 500);
   endfunction

   function automatic logic [31:0] pick_time();
      logic [63:0] t;
      logic [31:0] slots;
      if (p_period == 0 || p_interval == 0 || $urandom_range(0, 4) == 0) return $urandom();
      slots = p_period / p_interval;
      t = p_period * $urandom_range(0, 3) + p_interval * $urandom_range(0, slots);
      case ($urandom_range(0, 2))
         0: ;
         1: t = t + p_interval - 1;
         default: t = t + $urandom_range(0, p_interval - 1);
      endcase
      return t[31:0];
   endfunction

   // sender
   always @(posedge clock) begin : drive_requests
      logic nxt_req_valid;
      logic nxt_csr_valid;
      access_type a;
      if (reset) begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
         gap_left     = 0;
         settle_left  = DRAIN_SETTLE;
         restore_defaults();
      end else begin
         nxt_req_valid = req_ch.valid;
         nxt_csr_valid = csr_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            a.mode     = req_ch.mode;
            a.time_now = req_ch.time_now;
            a.time_new = req_ch.time_new;
            expected_mappings.push_back(map_access(a));
            access_count++;
            if (a.mode == MODE_CLOCK_CHANGE) clock_change_count++;
            nxt_req_valid = 1'b0;
            gap_left      = pick_gap();
         end
         if (csr_ch.valid && csr_ch.ready) begin
            write_register(csr_ch.index, csr_ch.data);
            csr_count++;
            nxt_csr_valid = 1'b0;
            gap_left      = pick_gap();
         end
         if (!nxt_req_valid && !nxt_csr_valid && pending.size() > 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               case (pending[0].kind)
                  CMD_ACCESS: begin
                     req_ch.mode     <= pending[0].acc.mode;
                     req_ch.time_now <= pending[0].acc.time_now;
                     req_ch.time_new <= pending[0].acc.time_new;
                     nxt_req_valid = 1'b1;
                     void'(pending.pop_front());
                  end
                  CMD_CSR: begin
                     csr_ch.index <= pending[0].index;
                     csr_ch.data  <= pending[0].data;
                     nxt_csr_valid = 1'b1;
                     void'(pending.pop_front());
                  end
                  CMD_DRAIN: begin
                     if (expected_mappings.size() == 0) begin
                        if (settle_left > 0) begin
                           settle_left--;
                        end else begin
                           settle_left = DRAIN_SETTLE;
                           void'(pending.pop_front());
                        end
                     end
                  end
                  default: begin
                     idle_off = pending[0].flag;
                     void'(pending.pop_front());
                  end
               endcase
            end
         end
         req_ch.valid <= nxt_req_valid;
         csr_ch.valid <= nxt_csr_valid;
      end
   end

   // receiver and checker
   always @(posedge clock) begin : check_responses
      mapping_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_mappings.size() == 0) begin
               report_mismatch("unexpected transaction, flash_address",
                               rsp_ch.flash_address, '0);
            end else begin
               want = expected_mappings.pop_front();
               if (rsp_ch.flash_address !== want.flash_address)
                  report_mismatch("flash_address", rsp_ch.flash_address, want.flash_address);
               if (rsp_ch.erase_before_write !== want.erase_before_write)
                  report_mismatch("erase_before_write", {31'd0, rsp_ch.erase_before_write},
                                  {31'd0, want.erase_before_write});
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", {31'd0, rsp_ch.status}, {31'd0, want.status});
               if (want.erase_before_write) erase_count++;
               if (want.status) invalid_count++;
            end
            stall_left = pick_gap();
         end else if (stall_left > 0) begin
            stall_left--;
         end else if ($urandom_range(0, 31) == 0) begin
            stall_left = pick_gap();
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   task automatic queue_access(logic [MODE_W-1:0] mode, logic [31:0] now, logic [31:0] nxt);
      command_type c;
      c.kind         = CMD_ACCESS;
      c.acc.mode     = mode;
      c.acc.time_now = now;
      c.acc.time_new = nxt;
      pending.push_back(c);
   endtask

   task automatic queue_command(command_kind_type kind, logic [CSR_INDEX_W-1:0] idx,
                                logic [CSR_DATA_W-1:0] value, bit flag);
      command_type c;
      c.kind  = kind;
      c.acc   = '0;
      c.index = idx;
      c.data  = value;
      c.flag  = flag;
      pending.push_back(c);
   endtask

   task automatic queue_layout(logic [31:0] base, logic [31:0] sector, logic [31:0] record,
                               logic [31:0] period, logic [31:0] interval);
      queue_command(CMD_DRAIN, '0, '0, 1'b0);
      queue_command(CMD_CSR, CSR_BASE_ADDRESS, base, 1'b0);
      queue_command(CMD_CSR, CSR_SECTOR_SIZE, sector, 1'b0);
      queue_command(CMD_CSR, CSR_RECORD_SIZE, record, 1'b0);
      queue_command(CMD_CSR, CSR_LOG_PERIOD, period, 1'b0);
      queue_command(CMD_CSR, CSR_SLOT_INTERVAL, interval, 1'b0);
      p_period   = period;
      p_interval = interval;
      layout_count++;
   endtask

   task automatic queue_random_layout(output bit broken);
      logic [31:0] rec;
      logic [31:0] sec;
      logic [31:0] intv;
      logic [31:0] per;
      logic [31:0] sec_data;
      logic [31:0] rec_data;
      broken = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
         0: rec = 1;
         1: rec = $urandom_range(1, 64);
         2: rec = 32'd1 << $urandom_range(0, 16);
         default: rec = $urandom_range(1, 65536);
      endcase
      sec = rec * $urandom_range(1, 8) + $urandom_range(0, rec - 1);
      if ($urandom_range(0, 9) == 0) sec = $urandom_range(rec, 33554431);
      intv = ($urandom_range(0, 7) == 0) ? ($urandom() | 32'd1) : $urandom_range(1, 100);
      per  = intv * $urandom_range(1, 64) + $urandom_range(0, intv - 1);
      if (broken) begin
         case ($urandom_range(0, 4))
            0: rec = 0;
            1: sec = rec - 1;
            2: per = 0;
            3: intv = 0;
            default: per = $urandom_range(0, intv - 1);
         endcase
      end
      sec_data = sec;
      rec_data = rec;
      if ($urandom_range(0, 3) == 0) sec_data[31:SECTOR_W] = (32 - SECTOR_W)'($urandom());
      if ($urandom_range(0, 3) == 0) rec_data[31:RECORD_W] = (32 - RECORD_W)'($urandom());
      queue_layout($urandom(), sec_data, rec_data, per, intv);
   endtask

   task automatic queue_random_access();
      int unsigned      r;
      logic [MODE_W-1:0] mode;
      logic [31:0]      now;
      logic [31:0]      nxt;
      r = $urandom_range(0, 99);
      if (r < 45)      mode = MODE_WRITE;
      else if (r < 75) mode = MODE_READ;
      else if (r < 95) mode = MODE_CLOCK_CHANGE;
      else             mode = MODE_UNUSED;
      now = pick_time();
      if (mode != MODE_CLOCK_CHANGE || $urandom_range(0, 1) == 0) nxt = pick_time();
      else nxt = now + p_interval * $urandom_range(0, 3);
      queue_access(mode, now, nxt);
   endtask

   initial begin
      int unsigned issued;
      int unsigned phase_items;
      bit          broken;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_READ;
      req_ch.time_now = '0;
      req_ch.time_new = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_BASE_ADDRESS;
      csr_ch.data  = '0;
      idle_off     = 1'b0;
      cycle_count  = 0;
      p_period     = RESET_LOG_PERIOD;
      p_interval   = RESET_SLOT_INTERVAL;

      // reset layout: first write, slot zero, sector boundaries, pending erase, wraps
      queue_access(MODE_WRITE, 32'd0, 32'd0);
      queue_access(MODE_WRITE, 32'd60, 32'hFFFF_FFFF);
      queue_access(MODE_WRITE, 32'd120, 32'd0);
      queue_access(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_access(MODE_UNUSED, 32'd12345, 32'd0);
      queue_access(MODE_CLOCK_CHANGE, 32'd60, 32'd60);
      queue_access(MODE_WRITE, 32'd180, 32'd0);
      queue_access(MODE_CLOCK_CHANGE, 32'd60, 32'd86340);
      queue_access(MODE_WRITE, 32'd240, 32'd0);
      queue_access(MODE_READ, 32'd86399, 32'd0);
      queue_access(MODE_READ, 32'd86400, 32'd0);
      queue_access(MODE_CLOCK_CHANGE, 32'hFFFF_FFFF, 32'd0);

      // address wrap at the top of the flash space
      queue_layout(32'hFFFF_FFF0, 32'd4096, 32'd16, 32'd86400, 32'd60);
      queue_access(MODE_WRITE, 32'd0, 32'd0);
      queue_access(MODE_READ, 32'd120, 32'd0);

      // sector of 2^24 and record of 2^16, longest period, shortest interval
      queue_layout(32'hFFFF_FFFF, 32'd16777216, 32'd65536, 32'hFFFF_FFFF, 32'd1);
      queue_access(MODE_READ, 32'd0, 32'd0);
      queue_access(MODE_CLOCK_CHANGE, 32'hFFFF_FFFE, 32'd1);

      // one record per sector: every address is sector aligned
      queue_layout(32'd0, 32'd1, 32'd1, 32'd5, 32'd1);
      queue_access(MODE_WRITE, 32'd1, 32'd0);
      queue_access(MODE_WRITE, 32'd2, 32'd0);
      queue_access(MODE_CLOCK_CHANGE, 32'd3, 32'd4);

      // all-ones register data, masked to field width
      queue_layout('1, '1, '1, '1, '1);
      queue_access(MODE_READ, 32'd0, 32'd0);
      queue_access(MODE_WRITE, 32'hFFFF_FFFF, 32'd0);

      // invalid layouts
      queue_layout(32'd0, 32'd4096, 32'd0, 32'd86400, 32'd60);
      queue_access(MODE_WRITE, 32'd60, 32'd0);
      queue_layout(32'd0, 32'd8, 32'd16, 32'd86400, 32'd60);
      queue_access(MODE_CLOCK_CHANGE, 32'd60, 32'd6000);
      queue_layout(32'd0, 32'd4096, 32'd16, 32'd0, 32'd60);
      queue_access(MODE_READ, 32'd60, 32'd0);
      queue_layout(32'd0, 32'd4096, 32'd16, 32'd86400, 32'd0);
      queue_access(MODE_WRITE, 32'd60, 32'd0);
      queue_layout(32'd0, 32'd4096, 32'd16, 32'd10, 32'd60);
      queue_access(MODE_READ, 32'd5, 32'd0);

      // writes to unused register indexes leave the pending erase alone
      queue_layout(32'd0, 32'd4096, 32'd16, 32'd86400, 32'd60);
      queue_access(MODE_WRITE, 32'd60, 32'd0);
      queue_command(CMD_DRAIN, '0, '0, 1'b0);
      queue_command(CMD_CSR, CSR_UNUSED_LO, $urandom(), 1'b0);
      queue_command(CMD_CSR, CSR_UNUSED_HI, $urandom(), 1'b0);
      queue_access(MODE_WRITE, 32'd120, 32'd0);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         queue_random_layout(broken);
         queue_command(CMD_PACE, '0, '0, $urandom_range(0, 3) == 0);
         phase_items = broken ? 6 : 40;
         repeat (phase_items) begin
            if ($urandom_range(0, 29) == 0) queue_command(CMD_DRAIN, '0, '0, 1'b0);
            queue_random_access();
         end
         issued += phase_items;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || req_ch.valid || csr_ch.valid || expected_mappings.size() > 0)
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      $display("Covered %0d access transactions (%0d clock changes) over %0d layouts",
               access_count, clock_change_count, layout_count);
      $display("%0d register writes, %0d erase-first results, %0d invalid-layout results",
               csr_count, erase_count, invalid_count);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
